[src/sc2a_pkg.sv]
// Shared types, action codes and the set-1 scancode decode table.
package sc2a_pkg;

  // Action codes carried on the request channel.
  localparam logic [1:0] ACT_SCAN  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Depth of the operation queue between front and back.
  localparam int OP_QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PRESS   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_POP     = 3'd3,
    OP_QUERY   = 3'd4
  } op_kind_e;

  // Classified request: kind plus decoded key code (or queried key index).
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] code;
  } op_t;

  // Set-1 scancode to ASCII; codes not in the table map to scancode + 128.
  function automatic logic [7:0] decode_scan(input logic [6:0] sc);
    logic [7:0] res;
    case (sc)
      7'd41: res = 8'h60;  // backquote
      7'd2:  res = 8'h31;
      7'd3:  res = 8'h32;
      7'd4:  res = 8'h33;
      7'd5:  res = 8'h34;
      7'd6:  res = 8'h35;
      7'd7:  res = 8'h36;
      7'd8:  res = 8'h37;
      7'd9:  res = 8'h38;
      7'd10: res = 8'h39;
      7'd11: res = 8'h30;
      7'd12: res = 8'h2D;
      7'd13: res = 8'h3D;
      7'd16: res = 8'h71;
      7'd17: res = 8'h77;
      7'd18: res = 8'h65;
      7'd19: res = 8'h72;
      7'd20: res = 8'h74;
      7'd21: res = 8'h79;
      7'd22: res = 8'h75;
      7'd23: res = 8'h69;
      7'd24: res = 8'h6F;
      7'd25: res = 8'h70;
      7'd26: res = 8'h5B;
      7'd27: res = 8'h5D;
      7'd43: res = 8'h5C;  // backslash
      7'd30: res = 8'h61;
      7'd31: res = 8'h73;
      7'd32: res = 8'h64;
      7'd33: res = 8'h66;
      7'd34: res = 8'h67;
      7'd35: res = 8'h68;
      7'd36: res = 8'h6A;
      7'd37: res = 8'h6B;
      7'd38: res = 8'h6C;
      7'd39: res = 8'h3B;
      7'd40: res = 8'h27;
      7'd44: res = 8'h7A;
      7'd45: res = 8'h78;
      7'd46: res = 8'h63;
      7'd47: res = 8'h76;
      7'd48: res = 8'h62;
      7'd49: res = 8'h6E;
      7'd50: res = 8'h6D;
      7'd51: res = 8'h2C;
      7'd52: res = 8'h2E;
      7'd53: res = 8'h2F;
      7'd57: res = 8'h20;  // space
      default: res = {1'b1, sc};
    endcase
    return res;
  endfunction

endpackage

[src/sc2a_intf.sv]
// Request and response channel interfaces.
interface sc2a_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] scancode;
  logic [7:0] key_index;

  modport source (output valid, action, scancode, key_index, input ready);
  modport sink   (input valid, action, scancode, key_index, output ready);
endinterface

interface sc2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       key_is_down;
  logic [5:0] fill_count;

  modport source (output valid, char_code, char_valid, key_is_down, fill_count, input ready);
  modport sink   (input valid, char_code, char_valid, key_is_down, fill_count, output ready);
endinterface

[src/sc2a_front.sv]
// Front end: accepts requests, decodes scancodes and classifies the operation.
module sc2a_front (
  sc2a_in_if.sink       req_i,
  output sc2a_pkg::op_t op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);

  logic release_bit;

  assign release_bit   = req_i.scancode[7];
  assign op_valid_o    = req_i.valid;
  assign req_i.ready   = op_ready_i;

  always_comb begin
    op_o.kind = sc2a_pkg::OP_NOP;
    op_o.code = 8'd0;
    case (req_i.action)
      sc2a_pkg::ACT_SCAN: begin
        // raw byte zero is dropped
        if (req_i.scancode != 8'd0) begin
          op_o.kind = release_bit ? sc2a_pkg::OP_RELEASE : sc2a_pkg::OP_PRESS;
          op_o.code = sc2a_pkg::decode_scan(req_i.scancode[6:0]);
        end
      end
      sc2a_pkg::ACT_POP: begin
        op_o.kind = sc2a_pkg::OP_POP;
      end
      sc2a_pkg::ACT_QUERY: begin
        op_o.kind = sc2a_pkg::OP_QUERY;
        op_o.code = req_i.key_index;
      end
      default: begin
        op_o.kind = sc2a_pkg::OP_NOP;
      end
    endcase
  end

endmodule

[src/sc2a_op_queue.sv]
// Two-entry queue of classified operations between front and back.
module sc2a_op_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sc2a_pkg::op_t in_op_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output sc2a_pkg::op_t out_op_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  localparam int PtrW = $clog2(sc2a_pkg::OP_QUEUE_DEPTH);
  localparam int CntW = $clog2(sc2a_pkg::OP_QUEUE_DEPTH + 1);

  sc2a_pkg::op_t entries_q [sc2a_pkg::OP_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(sc2a_pkg::OP_QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_op_o    = entries_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(sc2a_pkg::OP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(sc2a_pkg::OP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_op_i;
    end
  end

endmodule

[src/sc2a_back.sv]
// Back end: key-down map, released-key FIFO and the registered response.
module sc2a_back #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sc2a_pkg::op_t op_i,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  sc2a_out_if.source    rsp_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]      mem_q [FIFO_DEPTH];
  logic [255:0]    map_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rsp_valid_q;
  logic [7:0]      char_code_q;
  logic            char_valid_q;
  logic            key_down_q;
  logic [5:0]      fill_q;

  logic            exec;
  logic            full, empty;
  logic [PtrW-1:0] head_next;
  logic [PtrW:0]   tail_sum;
  logic [PtrW-1:0] wr_addr;
  logic            wr_en;
  logic            pop_hit;

  assign op_ready_o = !rsp_valid_q || rsp_o.ready;
  assign exec       = op_valid_i && op_ready_o;
  assign full       = (cnt_q == CntW'(FIFO_DEPTH));
  assign empty      = (cnt_q == '0);
  assign head_next  = (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum   = (PtrW+1)'(head_q) + (PtrW+1)'(cnt_q);

  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    pop_hit = 1'b0;
    if (exec) begin
      case (op_i.kind)
        sc2a_pkg::OP_RELEASE: begin
          wr_en = 1'b1;
          if (full) begin
            // overwrite oldest slot and move head past it
            wr_addr = head_q;
            head_d  = head_next;
          end else begin
            wr_addr = (tail_sum >= (PtrW+1)'(FIFO_DEPTH))
                      ? PtrW'(tail_sum - (PtrW+1)'(FIFO_DEPTH)) : PtrW'(tail_sum);
            cnt_d   = cnt_q + 1'b1;
          end
        end
        sc2a_pkg::OP_POP: begin
          if (!empty) begin
            pop_hit = 1'b1;
            head_d  = head_next;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        default: begin
          head_d = head_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      map_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (exec && (op_i.kind == sc2a_pkg::OP_PRESS)) begin
        map_q[op_i.code] <= 1'b1;
      end else if (exec && (op_i.kind == sc2a_pkg::OP_RELEASE)) begin
        map_q[op_i.code] <= 1'b0;
      end
      if (exec) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // FIFO storage with registered read into the response
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= op_i.code;
    end
    if (exec) begin
      char_code_q  <= pop_hit ? mem_q[head_q] : 8'd0;
      char_valid_q <= pop_hit;
      key_down_q   <= (op_i.kind == sc2a_pkg::OP_QUERY) ? map_q[op_i.code] : 1'b0;
      fill_q       <= 6'(cnt_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.char_code   = char_code_q;
  assign rsp_o.char_valid  = char_valid_q;
  assign rsp_o.key_is_down = key_down_q;
  assign rsp_o.fill_count  = fill_q;

endmodule

[src/scancode_to_ascii_key_fifo.sv]
// Top level: set-1 scancode decoder with key-down map and released-key FIFO.
//
// Each request carries one action: a raw scancode byte (bit 7 marks a
// release), a pop of the oldest released key, or a query of one key's
// down state. Every request yields exactly one response, in order, with
// char_code/char_valid for pops, key_is_down for queries and the FIFO
// fill_count after the request. Scancodes outside the 48-key table decode
// to scancode + 128; a raw zero byte changes nothing. A release pushes its
// decoded code; when the FIFO holds FIFO_DEPTH codes the oldest one is
// dropped. A pop on an empty FIFO returns char_valid = 0. fill_count shows
// the low six bits of the count. Throughput is one request per cycle while
// the response side takes responses: the front decodes in the accept cycle,
// a two-entry queue holds classified requests, and the back updates map and
// FIFO and registers the response. A request is registered in the queue and
// its response then in the back's response register. The key-down map is
// cleared by reset, no sweep needed.
module scancode_to_ascii_key_fifo #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sc2a_in_if.sink    req_i,
  sc2a_out_if.source rsp_o
);

  sc2a_pkg::op_t front_op;
  logic          front_valid;
  logic          front_ready;
  sc2a_pkg::op_t back_op;
  logic          back_valid;
  logic          back_ready;

  // classify incoming requests
  sc2a_front u_front (
    .req_i      (req_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready)
  );

  // decouples request side from response backpressure
  sc2a_op_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (front_op),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_op_o    (back_op),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready)
  );

  // state update and response register
  sc2a_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (back_op),
    .op_valid_i (back_valid),
    .op_ready_o (back_ready),
    .rsp_o      (rsp_o)
  );

endmodule

[tb/scancode_to_ascii_key_fifo_tb.sv]
// Self-checking testbench for the scancode decoder with key-down map and released-key FIFO.
module scancode_to_ascii_key_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIFO_DEPTH   = 32;
  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either channel
  localparam int PHASE_ITEMS  = 456;
  localparam int BURST_LEN    = 40;
  localparam int DRAIN_CYCLES = 8;     // response passes the queue and the response register after its request

  // Action code 3 is not defined by the package; the block must leave state alone.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Release-heavy bursts fill the FIFO past its depth, pop-heavy ones empty it.
  typedef enum int {BIAS_RELEASE, BIAS_MIXED, BIAS_POP} burst_bias_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] scancode;
    logic [7:0] key_index;
  } key_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       key_is_down;
    logic [5:0] fill_count;
  } key_rsp_t;

  // Tracks the key map and the released-key FIFO, and holds the responses
  // still owed by the block in request order.
  class key_fifo_scoreboard;
    bit          key_down [256];
    logic [7:0]  released_q[$];
    key_rsp_t    pending_q[$];
    int          mismatches;
    int          checked;
    int          drops;
    int          valid_pops;
    int          down_hits;
    int          peak_fill;

    // Set-1 layout; anything outside the 48 keys maps to scancode + 128.
    function logic [7:0] decode(logic [6:0] sc);
      case (sc)
        7'd41: return 8'h60;  // backquote
        7'd2:  return "1";
        7'd3:  return "2";
        7'd4:  return "3";
        7'd5:  return "4";
        7'd6:  return "5";
        7'd7:  return "6";
        7'd8:  return "7";
        7'd9:  return "8";
        7'd10: return "9";
        7'd11: return "0";
        7'd12: return "-";
        7'd13: return "=";
        7'd16: return "q";
        7'd17: return "w";
        7'd18: return "e";
        7'd19: return "r";
        7'd20: return "t";
        7'd21: return "y";
        7'd22: return "u";
        7'd23: return "i";
        7'd24: return "o";
        7'd25: return "p";
        7'd26: return "[";
        7'd27: return "]";
        7'd43: return "\\";
        7'd30: return "a";
        7'd31: return "s";
        7'd32: return "d";
        7'd33: return "f";
        7'd34: return "g";
        7'd35: return "h";
        7'd36: return "j";
        7'd37: return "k";
        7'd38: return "l";
        7'd39: return ";";
        7'd40: return "'";
        7'd44: return "z";
        7'd45: return "x";
        7'd46: return "c";
        7'd47: return "v";
        7'd48: return "b";
        7'd49: return "n";
        7'd50: return "m";
        7'd51: return ",";
        7'd52: return ".";
        7'd53: return "/";
        7'd57: return " ";
        default: return {1'b1, sc};
      endcase
    endfunction

    function void note_request(key_req_t req);
      key_rsp_t   exp_rsp;
      logic [7:0] code;
      exp_rsp = '0;
      case (req.action)
        sc2a_pkg::ACT_SCAN: begin
          if (req.scancode != 8'd0) begin
            code = decode(req.scancode[6:0]);
            key_down[code] = !req.scancode[7];
            if (req.scancode[7]) begin
              // Full FIFO drops its oldest code to make room.
              if (released_q.size() >= FIFO_DEPTH) begin
                void'(released_q.pop_front());
                drops++;
              end
              released_q.push_back(code);
            end
          end
        end
        sc2a_pkg::ACT_POP: begin
          if (released_q.size() > 0) begin
            exp_rsp.char_code  = released_q.pop_front();
            exp_rsp.char_valid = 1'b1;
            valid_pops++;
          end
        end
        sc2a_pkg::ACT_QUERY: begin
          exp_rsp.key_is_down = key_down[req.key_index];
          if (exp_rsp.key_is_down) down_hits++;
        end
        default: ;
      endcase
      exp_rsp.fill_count = 6'(released_q.size());
      if (released_q.size() > peak_fill) peak_fill = released_q.size();
      pending_q.push_back(exp_rsp);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH response %0d: %s", $realtime, checked, what);
      mismatches++;
    endtask

    task check_response(key_rsp_t got);
      key_rsp_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = pending_q.pop_front();
      if (got.char_code !== want.char_code)
        report_mismatch($sformatf("char_code %h, want %h", got.char_code, want.char_code));
      if (got.char_valid !== want.char_valid)
        report_mismatch($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
      if (got.key_is_down !== want.key_is_down)
        report_mismatch($sformatf("key_is_down %b, want %b", got.key_is_down, want.key_is_down));
      if (got.fill_count !== want.fill_count)
        report_mismatch($sformatf("fill_count %0d, want %0d", got.fill_count, want.fill_count));
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sc2a_in_if  req_if ();
  sc2a_out_if rsp_if ();

  scancode_to_ascii_key_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  key_fifo_scoreboard sb = new();

  int idle_pct;    // chance per cycle that the request side holds back
  int stall_pct;   // chance per cycle that the response side is not ready
  int n_scan, n_pop, n_query, n_unused;
  logic [6:0] held_q[$];  // scancodes pressed and not yet released

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Response side: ready toggles at the falling edge, so the block sees a
  // settled value at every rising edge.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every response handshake goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response({rsp_if.char_code, rsp_if.char_valid,
                         rsp_if.key_is_down, rsp_if.fill_count});
  end

  // Watchdog: a long stretch with no handshake means the block hung.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic key_req_t mk_req(logic [1:0] act, logic [7:0] sc, logic [7:0] ki);
    key_req_t r;
    r.action    = act;
    r.scancode  = sc;
    r.key_index = ki;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the
  // request was taken. valid stays high between back-to-back requests.
  task automatic send_request(key_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= req.action;
    req_if.scancode  <= req.scancode;
    req_if.key_index <= req.key_index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(req);
    case (req.action)
      sc2a_pkg::ACT_SCAN:  n_scan++;
      sc2a_pkg::ACT_POP:   n_pop++;
      sc2a_pkg::ACT_QUERY: n_query++;
      default:             n_unused++;
    endcase
    @(negedge clk_i);
  endtask

  // Hold off new requests until every outstanding response is back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Mostly codes 1 to 57, which hold the table keys, sometimes any 7-bit code.
  function automatic logic [6:0] pick_scancode();
    if ($urandom_range(99) < 75) return 7'($urandom_range(57, 1));
    return 7'($urandom_range(127));
  endfunction

  task automatic random_request(burst_bias_e bias);
    int         roll;
    int         scan_w, pop_w, query_w, release_w;
    logic [6:0] sc;
    logic [7:0] ki;
    case (bias)
      BIAS_RELEASE: begin scan_w = 70; pop_w = 10; query_w = 15; release_w = 75; end
      BIAS_POP:     begin scan_w = 30; pop_w = 50; query_w = 17; release_w = 50; end
      default:      begin scan_w = 45; pop_w = 30; query_w = 20; release_w = 50; end
    endcase
    roll = $urandom_range(99);
    if (roll < scan_w) begin
      if ($urandom_range(99) < 2) begin
        send_request(mk_req(sc2a_pkg::ACT_SCAN, 8'd0, 8'($urandom)));  // ignored byte
      end else if ($urandom_range(99) < release_w) begin
        // Release a held key when there is one, else any code.
        if (held_q.size() > 0 && $urandom_range(1)) sc = held_q.pop_front();
        else sc = pick_scancode();
        send_request(mk_req(sc2a_pkg::ACT_SCAN, {1'b1, sc}, 8'($urandom)));
      end else begin
        sc = pick_scancode();
        if (held_q.size() < 16) held_q.push_back(sc);
        send_request(mk_req(sc2a_pkg::ACT_SCAN, {1'b0, sc}, 8'($urandom)));
      end
    end else if (roll < scan_w + pop_w) begin
      send_request(mk_req(sc2a_pkg::ACT_POP, 8'($urandom), 8'($urandom)));
    end else if (roll < scan_w + pop_w + query_w) begin
      // Half the queries aim at keys likely to be down.
      if ($urandom_range(1) && held_q.size() > 0)
        ki = sb.decode(held_q[$urandom_range(held_q.size() - 1)]);
      else if ($urandom_range(1))
        ki = sb.decode(pick_scancode());
      else
        ki = 8'($urandom);
      send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'($urandom), ki));
    end else begin
      send_request(mk_req(ACT_UNUSED, 8'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    int         phase_idle [4];
    int         phase_stall[4];
    int         left;
    int         burst;
    burst_bias_e bias;

    // Phases: no idling, idle request side, stalling response side, both.
    phase_idle  = '{0, 55, 0, 15};
    phase_stall = '{0, 0, 55, 15};

    idle_pct  = 0;
    stall_pct = 0;
    n_scan = 0; n_pop = 0; n_query = 0; n_unused = 0;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = sc2a_pkg::ACT_SCAN;
    req_if.scancode  = 8'd0;
    req_if.key_index = 8'd0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty pop, map extremes, table corners, unmapped codes,
    // ignored zero byte, unused action, and pops back to empty.
    send_request(mk_req(sc2a_pkg::ACT_POP,   8'h00, 8'h00));  // pop on empty FIFO
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'h00, 8'h00));
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'hFF, 8'hFF));
    send_request(mk_req(ACT_UNUSED,          8'hFF, 8'hFF));
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h00, 8'hFF));  // zero byte is ignored
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h01, 8'h00));  // unmapped, decodes to 129
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'h00, 8'h81));
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h29, 8'h00));  // backquote
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h2B, 8'h00));  // backslash
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h39, 8'h00));  // space
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h7F, 8'h00));  // highest code, maps to 255
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'h00, 8'hFF));
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'h00, 8'h60));
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'hFF, 8'h00));  // release of the highest code
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'h80, 8'h00));  // release of code zero
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'hA9, 8'h00));
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'hAB, 8'h00));
    send_request(mk_req(sc2a_pkg::ACT_SCAN,  8'hB9, 8'h00));
    send_request(mk_req(sc2a_pkg::ACT_QUERY, 8'h00, 8'h20));
    send_request(mk_req(ACT_UNUSED,          8'h00, 8'h00));
    // last pop finds the FIFO empty
    repeat (6) send_request(mk_req(sc2a_pkg::ACT_POP, 8'h00, 8'h00));
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      left      = PHASE_ITEMS;
      while (left > 0) begin
        bias  = burst_bias_e'($urandom_range(2));
        burst = (left < BURST_LEN) ? left : BURST_LEN;
        for (int i = 0; i < burst; i++) random_request(bias);
        left -= burst;
        // Once per phase the request side waits for the block to empty out.
        if (left > 0 && left <= BURST_LEN * 5 && left > BURST_LEN * 4)
          drain_responses();
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d scancode, %0d pop, %0d query and %0d unused-action requests",
             n_scan, n_pop, n_query, n_unused);
    $display("%0d pops returned a key, %0d queries found a key down, %0d overflow drops, peak fill %0d",
             sb.valid_pops, sb.down_hits, sb.drops, sb.peak_fill);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
src/sc2a_pkg.sv
src/sc2a_intf.sv
src/sc2a_front.sv
src/sc2a_op_queue.sv
src/sc2a_back.sv
src/scancode_to_ascii_key_fifo.sv
tb/scancode_to_ascii_key_fifo_tb.sv
